// File: hw/rtl/rmih_pkg.sv
// Package for the running mode tracker: add/remove mode codes.
// No dependencies.
package rmih_pkg;
    localparam logic MODE_ADD_BIT = 1'b0;
    localparam logic MODE_REMOVE_BIT = 1'b1;
endpackage

// File: hw/rtl/rmih_stream_if.sv
// Valid/ready stream interface with a generic payload width.
// Depends on nothing.
interface rmih_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/running_mode_indexed_heap.sv
// Running mode tracker: value counts in an indexed binary max-heap held in
// synchronous memories (entry memory and position/presence memory, registered reads).
// An ignored transaction goes straight to the result; an add sifts the entry up
// the heap and a remove sifts it down, level by level.
// One transaction at a time; the next is accepted the cycle after its result is
// registered, later while an earlier result still waits in the output register.
// Reset clears heap size, then a pass over every value clears the presence bits
// with the input held not ready; the entry memory is not cleared.
module running_mode_indexed_heap
    import rmih_pkg::*;
#(
    parameter int VALUE_BITS = 10,
    parameter int COUNT_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    rmih_stream_if.sink   in_s,
    rmih_stream_if.source out_s
);
    localparam int N = 1 << VALUE_BITS;
    localparam int E = VALUE_BITS + COUNT_BITS;
    typedef logic [VALUE_BITS-1:0] idx_t;
    typedef logic [VALUE_BITS:0]   size_t;
    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef enum logic [3:0] {S_CLR, S_IDLE, S_POS, S_CUR, S_MOD, S_UPRD, S_UPCMP,
                              S_DNRD, S_DNR2, S_DNCMP, S_TOP, S_TOPW, S_OUT} st_t;

    logic [E-1:0]      ent_mem [N];
    // presence flag on top of the heap position
    logic [VALUE_BITS:0] pos_mem [N];

    st_t   st_reg;
    size_t size_reg;
    idx_t  clr_reg;
    logic  rm_reg;
    idx_t  v_reg, p_reg, q_reg;
    idx_t  cv_reg;
    cnt_t  cc_reg;
    idx_t  bv_reg;
    cnt_t  bc_reg;
    idx_t  bp_reg;
    logic  bsel_reg;

    // memory ports
    logic  ea_we; idx_t ea_wa; logic [E-1:0] ea_wd;
    idx_t  e_ra;  logic [E-1:0] e_rd_reg;
    logic  pa_we; idx_t pa_wa; logic [VALUE_BITS:0] pa_wd;
    idx_t  p_ra;  logic [VALUE_BITS:0] p_rd_reg;

    logic [VALUE_BITS+COUNT_BITS:0] out_reg;
    assign out_s.data  = out_reg;
    assign in_s.ready  = (st_reg == S_IDLE);

    always_ff @(posedge clk)
    begin
        if (ea_we) ent_mem[ea_wa] <= ea_wd;
        e_rd_reg <= ent_mem[e_ra];
        if (pa_we) pos_mem[pa_wa] <= pa_wd;
        p_rd_reg <= pos_mem[p_ra];
    end

    idx_t rv; cnt_t rc;
    assign rv = e_rd_reg[E-1:COUNT_BITS];
    assign rc = e_rd_reg[COUNT_BITS-1:0];

    function automatic logic below(cnt_t ca, idx_t va, cnt_t cb, idx_t vb);
        below = (ca == cb) ? (va < vb) : (ca < cb);
    endfunction

    size_t lft, rgt;
    assign lft = {p_reg, 1'b1};
    assign rgt = {p_reg, 1'b0} + size_t'(2);

    // right child outranks the best of current and left
    logic dn_right;
    assign dn_right = (rgt < size_reg) && below(bc_reg, bv_reg, rc, rv);

    always_comb
    begin
        ea_we = 1'b0; ea_wa = p_reg; ea_wd = {cv_reg, cc_reg};
        pa_we = 1'b0; pa_wa = cv_reg; pa_wd = {1'b1, p_reg};
        e_ra  = p_reg; p_ra = in_s.data[VALUE_BITS-1:0];
        case (st_reg)
            S_CLR:
            begin
                pa_we = 1'b1; pa_wa = clr_reg; pa_wd = '0;
            end
            S_POS:   e_ra = p_rd_reg[VALUE_BITS-1:0];
            S_UPRD:  e_ra = idx_t'((p_reg - 1'b1) >> 1);
            S_UPCMP:
                if (below(rc, rv, cc_reg, cv_reg))
                begin
                    // parent moves down to p, current moves up
                    ea_we = 1'b1; ea_wa = p_reg; ea_wd = {rv, rc};
                    pa_we = 1'b1; pa_wa = rv;   pa_wd = {1'b1, p_reg};
                end
            S_DNRD:  e_ra = lft[VALUE_BITS-1:0];
            S_DNR2:  e_ra = rgt[VALUE_BITS-1:0];
            S_DNCMP:
                if (dn_right)
                begin
                    ea_we = 1'b1; ea_wa = p_reg; ea_wd = {rv, rc};
                    pa_we = 1'b1; pa_wa = rv; pa_wd = {1'b1, p_reg};
                end
                else if (bsel_reg)
                begin
                    ea_we = 1'b1; ea_wa = p_reg; ea_wd = {bv_reg, bc_reg};
                    pa_we = 1'b1; pa_wa = bv_reg; pa_wd = {1'b1, p_reg};
                end
            S_TOPW:
            begin
                ea_we = 1'b1; ea_wa = p_reg; ea_wd = {cv_reg, cc_reg};
                pa_we = 1'b1; pa_wa = cv_reg; pa_wd = {1'b1, p_reg};
            end
            // top entry stays on the read port while the result waits
            S_TOP, S_OUT: e_ra = '0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= S_CLR;
            clr_reg     <= '0;
            size_reg    <= '0;
            out_s.valid <= 1'b0;
        end
        else
        begin
            case (st_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1)
                        st_reg <= S_IDLE;
                end
                S_IDLE:
                    if (in_s.valid)
                    begin
                        rm_reg <= in_s.data[VALUE_BITS];
                        v_reg  <= in_s.data[VALUE_BITS-1:0];
                        st_reg <= S_POS;
                    end
                S_POS:
                begin
                    p_reg <= p_rd_reg[VALUE_BITS-1:0];
                    if (!p_rd_reg[VALUE_BITS])
                    begin
                        if (rm_reg == MODE_REMOVE_BIT || size_reg[VALUE_BITS])
                            st_reg <= S_TOP;
                        else
                        begin
                            p_reg  <= size_reg[VALUE_BITS-1:0];
                            cv_reg <= v_reg; cc_reg <= cnt_t'(1);
                            size_reg <= size_reg + 1'b1;
                            st_reg <= S_UPRD;
                        end
                    end
                    else
                        st_reg <= S_CUR;
                end
                S_CUR: st_reg <= S_MOD;
                S_MOD:
                begin
                    cv_reg <= rv;
                    if (rm_reg == MODE_ADD_BIT)
                    begin
                        if (rc == '1) st_reg <= S_TOP;
                        else begin cc_reg <= rc + 1'b1; st_reg <= S_UPRD; end
                    end
                    else
                    begin
                        if (rc == '0) st_reg <= S_TOP;
                        else begin cc_reg <= rc - 1'b1; st_reg <= S_DNRD; end
                    end
                end
                S_UPRD:
                    if (p_reg == '0) st_reg <= S_TOPW;
                    else
                    begin
                        q_reg  <= idx_t'((p_reg - 1'b1) >> 1);
                        st_reg <= S_UPCMP;
                    end
                S_UPCMP:
                    if (below(rc, rv, cc_reg, cv_reg))
                    begin
                        p_reg  <= q_reg;
                        st_reg <= S_UPRD;
                    end
                    else st_reg <= S_TOPW;
                S_DNRD:
                begin
                    bv_reg <= cv_reg; bc_reg <= cc_reg; bsel_reg <= 1'b0;
                    if (lft >= size_reg) st_reg <= S_TOPW;
                    else st_reg <= S_DNR2;
                end
                S_DNR2:
                begin
                    // left child data available
                    if (below(cc_reg, cv_reg, rc, rv))
                    begin
                        bv_reg <= rv; bc_reg <= rc; bsel_reg <= 1'b1;
                        bp_reg <= lft[VALUE_BITS-1:0];
                    end
                    st_reg <= S_DNCMP;
                end
                S_DNCMP:
                begin
                    // right child data available (if in range)
                    if (dn_right)
                    begin
                        p_reg  <= rgt[VALUE_BITS-1:0];
                        st_reg <= S_DNRD;
                    end
                    else if (bsel_reg)
                    begin
                        p_reg  <= bp_reg;
                        st_reg <= S_DNRD;
                    end
                    else st_reg <= S_TOPW;
                end
                S_TOPW: st_reg <= S_TOP;
                S_TOP:  st_reg <= S_OUT;
                S_OUT:
                    if (!out_s.valid || out_s.ready)
                    begin
                        if (size_reg == '0) out_reg <= {{VALUE_BITS+COUNT_BITS{1'b0}}, 1'b1};
                        else out_reg <= {rv, rc, rc == '0};
                        out_s.valid <= 1'b1;
                        st_reg <= S_IDLE;
                    end
                default: st_reg <= S_IDLE;
            endcase
            if (st_reg != S_OUT && out_s.valid && out_s.ready)
                out_s.valid <= 1'b0;
        end
    end
endmodule

// File: sim/tb_running_mode_indexed_heap_chk.sv
// Checker for the running mode tracker: watches both streams, keeps its own
// copy of the counting heap, and compares every result against it.
// Depends on rmih_pkg.
`timescale 1ns / 100ps
module tb_running_mode_indexed_heap_chk
    import rmih_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [10:0] in_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [26:0] out_data,
    output int         fail_count,
    output int         pending_modes
);
    typedef struct packed {
        logic [9:0]  value;
        logic [15:0] count;
        logic        empty;
    } mode_rpt_t;

    localparam int NUM_VALUES = 1024;
    localparam logic [15:0] COUNT_SAT = 16'hFFFF;

    logic [9:0]  hp_value [NUM_VALUES];
    logic [15:0] hp_count [NUM_VALUES];
    int          slot_of  [NUM_VALUES];
    bit          seen     [NUM_VALUES];
    int          heap_len;
    mode_rpt_t   mode_q[$];

    function automatic bit lower_rank(int p, int q);
        if (hp_count[p] == hp_count[q])
            return hp_value[p] < hp_value[q];
        return hp_count[p] < hp_count[q];
    endfunction

    function automatic void swap_slots(int p, int q);
        logic [9:0]  v;
        logic [15:0] c;
        v = hp_value[p];
        c = hp_count[p];
        hp_value[p] = hp_value[q];
        hp_count[p] = hp_count[q];
        hp_value[q] = v;
        hp_count[q] = c;
        slot_of[hp_value[p]] = p;
        slot_of[hp_value[q]] = q;
    endfunction

    function automatic void bubble_up(int p);
        int par;
        while (p > 0)
        begin
            par = (p - 1) / 2;
            if (!lower_rank(par, p))
                break;
            swap_slots(par, p);
            p = par;
        end
    endfunction

    function automatic void bubble_down(int p);
        int l, r, best;
        while (p < heap_len)
        begin
            l = 2 * p + 1;
            r = 2 * p + 2;
            best = p;
            if (l < heap_len && lower_rank(best, l))
                best = l;
            if (r < heap_len && lower_rank(best, r))
                best = r;
            if (best == p)
                break;
            swap_slots(p, best);
            p = best;
        end
    endfunction

    function automatic mode_rpt_t track_mode(logic rm, logic [9:0] v);
        mode_rpt_t r;
        int p;
        if (rm == MODE_ADD_BIT)
        begin
            if (seen[v])
            begin
                p = slot_of[v];
                if (hp_count[p] != COUNT_SAT)
                begin
                    hp_count[p] = hp_count[p] + 16'd1;
                    bubble_up(p);
                end
            end
            else if (heap_len < NUM_VALUES)
            begin
                p = heap_len;
                hp_value[p] = v;
                hp_count[p] = 16'd1;
                slot_of[v] = p;
                seen[v] = 1'b1;
                heap_len++;
                bubble_up(p);
            end
        end
        else if (seen[v])
        begin
            p = slot_of[v];
            if (hp_count[p] != 16'd0)
            begin
                hp_count[p] = hp_count[p] - 16'd1;
                bubble_down(p);
            end
        end
        if (heap_len == 0)
            r = '{value: '0, count: '0, empty: 1'b1};
        else
            r = '{value: hp_value[0], count: hp_count[0], empty: hp_count[0] == 16'd0};
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mode_rpt_t exp_r, got;
        if (!rst_n)
        begin
            foreach (seen[i])
                seen[i] = 1'b0;
            heap_len = 0;
            mode_q.delete();
            fail_count = 0;
            pending_modes = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                mode_q.insert(mode_q.size(), track_mode(in_data[10], in_data[9:0]));
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (mode_q.size() == 0)
                begin
                    $error("unexpected result transaction %h", out_data);
                    fail_count++;
                end
                else
                begin
                    exp_r = mode_q.pop_front();
                    if (got.value !== exp_r.value)
                    begin
                        $error("mode_value: expected %0d, actual %0d", exp_r.value, got.value);
                        fail_count++;
                    end
                    if (got.count !== exp_r.count)
                    begin
                        $error("mode_count: expected %0d, actual %0d", exp_r.count, got.count);
                        fail_count++;
                    end
                    if (got.empty !== exp_r.empty)
                    begin
                        $error("set_empty: expected %0d, actual %0d", exp_r.empty, got.empty);
                        fail_count++;
                    end
                end
            end
            pending_modes = mode_q.size();
        end
    end
endmodule

// File: sim/tb_running_mode_indexed_heap.sv
// Testbench top for the running mode tracker: clock, reset, add/remove
// stimulus, output backpressure and the verdict.
// Depends on rmih_pkg, rmih_stream_if, running_mode_indexed_heap and tb_running_mode_indexed_heap_chk.
`timescale 1ns / 100ps
module tb_running_mode_indexed_heap
    import rmih_pkg::*;
();

    localparam int RANDOM_ITEMS = 1430;
    localparam int STALL_LIMIT  = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending_modes;
    int   cycle_cnt = 0;
    int   quiet_cnt = 0;
    int   hold_left = 0;
    int   sent = 0;

    rmih_stream_if #(.W(11)) in_if ();
    rmih_stream_if #(.W(27)) out_if ();

    running_mode_indexed_heap i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_s  (in_if.sink),
        .out_s (out_if.source)
    );

    tb_running_mode_indexed_heap_chk i_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_if.valid),
        .in_ready      (in_if.ready),
        .in_data       (in_if.data),
        .out_valid     (out_if.valid),
        .out_ready     (out_if.ready),
        .out_data      (out_if.data),
        .fail_count    (fail_count),
        .pending_modes (pending_modes)
    );

    always #5 clk = ~clk;

    initial
    begin
        in_if.valid = 1'b0;
        in_if.data  = '0;
        out_if.ready = 1'b0;
    end

    // Result side: random stalls, one long hold-off, one stretch always ready.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == 4000)
            hold_left <= 400;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_if.ready <= 1'b0;
        end
        else if (cycle_cnt > 20000 && cycle_cnt < 26000)
            out_if.ready <= 1'b1;
        else
            out_if.ready <= ($urandom_range(99) >= 31);
    end

    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_sample(logic rm, logic [9:0] v);
        in_if.valid <= 1'b1;
        in_if.data  <= {rm, v};
        do
            @(posedge clk);
        while (!in_if.ready);
        sent++;
        // no gaps on the sender side through a middle stretch of items
        if ((sent < 600 || sent > 850) && $urandom_range(99) < 31)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    initial
    begin
        logic       rm;
        logic [9:0] v;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty heap, removes of absent values, extremes, ties, all-zero counts
        push_sample(MODE_REMOVE_BIT, 10'd5);
        push_sample(MODE_ADD_BIT, 10'd0);
        push_sample(MODE_ADD_BIT, 10'd1023);
        push_sample(MODE_REMOVE_BIT, 10'd512);
        push_sample(MODE_ADD_BIT, 10'd341);
        push_sample(MODE_ADD_BIT, 10'd682);
        push_sample(MODE_ADD_BIT, 10'd0);
        push_sample(MODE_ADD_BIT, 10'd0);
        push_sample(MODE_ADD_BIT, 10'd1023);
        push_sample(MODE_ADD_BIT, 10'd1023);
        push_sample(MODE_REMOVE_BIT, 10'd0);
        push_sample(MODE_REMOVE_BIT, 10'd1023);
        push_sample(MODE_REMOVE_BIT, 10'd0);
        push_sample(MODE_REMOVE_BIT, 10'd0);
        push_sample(MODE_REMOVE_BIT, 10'd1023);
        push_sample(MODE_REMOVE_BIT, 10'd1023);
        push_sample(MODE_REMOVE_BIT, 10'd341);
        push_sample(MODE_REMOVE_BIT, 10'd682);
        push_sample(MODE_REMOVE_BIT, 10'd682);
        push_sample(MODE_ADD_BIT, 10'd682);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // mostly a small pool so counts climb, tie and sift both ways
            rm = ($urandom_range(99) < 42) ? MODE_REMOVE_BIT : MODE_ADD_BIT;
            if ($urandom_range(99) < 75)
                v = 10'($urandom_range(15)) | (n[8] ? 10'h3F0 : 10'h000);
            else
                v = 10'($urandom);
            push_sample(rm, v);
            if (n == 700)
            begin
                in_if.valid <= 1'b0;
                @(posedge clk);
                while (pending_modes != 0)
                    @(posedge clk);
            end
        end
        in_if.valid <= 1'b0;

        @(posedge clk);
        while (pending_modes != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
